// ===== rtl/plsr_pkg.sv =====
// Shared types and constants for the position loop with settle detection and slew limit.
// No dependencies; imported by every module of the block.
`default_nettype none

package plsr_pkg;

  localparam int unsigned AngleW = 15;
  localparam int unsigned RateW  = 24;
  localparam int unsigned GainW  = 16;
  localparam int unsigned SlewW  = 16;
  localparam int unsigned ALimW  = 14;
  localparam int unsigned RLimW  = 23;
  localparam int unsigned RunW   = 4;

  localparam logic [RunW-1:0] SETTLE_COUNT = 4'd10;
  localparam logic [RunW-1:0] RUN_MAX      = 4'd15;

  localparam logic signed [15:0] PI_Q12     = 16'sd12868;
  localparam logic signed [15:0] TWO_PI_Q12 = 16'sd25736;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 32;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_GAIN_ANGLE  = 3'd0,
    REG_GAIN_RATE   = 3'd1,
    REG_SPEED_CEIL  = 3'd2,
    REG_SPEED_FLOOR = 3'd3,
    REG_SLEW_STEP   = 3'd4,
    REG_ENTER_ANGLE = 3'd5,
    REG_EXIT_ANGLE  = 3'd6,
    REG_ENTER_RATE  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [GainW-1:0] gain_angle;
    logic [GainW-1:0] gain_rate;
    logic [RateW-1:0] speed_ceiling;
    logic [RateW-1:0] speed_floor;
    logic [SlewW-1:0] slew_step;
    logic [ALimW-1:0] enter_angle_limit;
    logic [ALimW-1:0] exit_angle_limit;
    logic [RLimW-1:0] enter_rate_limit;
  } cfg_t;

  typedef struct packed {
    logic [AngleW-1:0] target_angle;
    logic [AngleW-1:0] measured_angle;
    logic [RateW-1:0]  measured_rate;
  } item_t;

  typedef struct packed {
    logic [RateW-1:0] speed_command;
    logic             in_position;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/position_loop_settle_and_slew.sv =====
// Top level: input register, per-tick datapath, result register and configuration port.
// Depends on plsr_pkg, plsr_cfg and plsr_core.
`default_nettype none

// Channel   Dir   Ports            Content
// s_axis    in    tvalid/tready    tdata: target_angle, measured_angle, measured_rate
// m_axis    out   tvalid/tready    tdata: speed_command, in_position
// cfg       in    valid/ready      index 0..7, data up to 24 bits
//
// One tick per cycle while m_axis_tready is high: an item waits in the input register
// and its result is computed and stored in the result register when the item advances.
// The loop state (settled, run counter, ramp) updates at the same edge as result_q.
// Reset clears the loop state and loads the default settings; no clearing pass.
// A stalled result holds the input register; both registers together keep the flow
// going while m_axis_tready is high.

module position_loop_settle_and_slew (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [14:0] target_angle, [29:15] measured_angle, [53:30] measured_rate, [55:54] zero
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [23:0] speed_command, [24] in_position, [31:25] zero
  output logic [31:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);
  import plsr_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  result_t result_d, result_q;
  logic    in_valid_q, out_valid_q, advance;

  plsr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  plsr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.target_angle   <= s_axis_tdata[14:0];
      item_q.measured_angle <= s_axis_tdata[29:15];
      item_q.measured_rate  <= s_axis_tdata[53:30];
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, result_q.in_position, result_q.speed_command};

`ifndef ASSERT_OFF
  a_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("pending item dropped from input register");

  a_settled_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[24]) |-> (m_axis_tdata[23:0] == 24'd0))
    else $error("nonzero speed reported while in position");
`endif

endmodule

`default_nettype wire

// ===== rtl/plsr_cfg.sv =====
// Configuration register file: eight loop settings written through an index/data channel.
// Depends on plsr_pkg.
`default_nettype none

module plsr_cfg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [23:0]       cfg_data_i,
  output plsr_pkg::cfg_t         cfg_o
);
  import plsr_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_GAIN_ANGLE:  cfg_d.gain_angle        = cfg_data_i[GainW-1:0];
        REG_GAIN_RATE:   cfg_d.gain_rate         = cfg_data_i[GainW-1:0];
        REG_SPEED_CEIL:  cfg_d.speed_ceiling     = cfg_data_i[RateW-1:0];
        REG_SPEED_FLOOR: cfg_d.speed_floor       = cfg_data_i[RateW-1:0];
        REG_SLEW_STEP:   cfg_d.slew_step         = cfg_data_i[SlewW-1:0];
        REG_ENTER_ANGLE: cfg_d.enter_angle_limit = cfg_data_i[ALimW-1:0];
        REG_EXIT_ANGLE:  cfg_d.exit_angle_limit  = cfg_data_i[ALimW-1:0];
        REG_ENTER_RATE:  cfg_d.enter_rate_limit  = cfg_data_i[RLimW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_angle        <= '0;
      cfg_q.gain_rate         <= '0;
      cfg_q.speed_ceiling     <= 24'h7FFFFF;
      cfg_q.speed_floor       <= 24'h800000;
      cfg_q.slew_step         <= 16'd8;
      cfg_q.enter_angle_limit <= 14'd21;
      cfg_q.exit_angle_limit  <= 14'd43;
      cfg_q.enter_rate_limit  <= 23'd286;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/plsr_core.sv =====
// Per-tick datapath: angle error wrap, settle hysteresis, state feedback, clamp and slew.
// Holds the loop state (settled flag, settle run counter, ramp). Depends on plsr_pkg.
`default_nettype none

module plsr_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire plsr_pkg::item_t   item_i,
  input  wire plsr_pkg::cfg_t    cfg_i,
  output plsr_pkg::result_t      result_o
);
  import plsr_pkg::*;

  logic                    settled_q, settled_d;
  logic [RunW-1:0]         run_q, run_d, run_inc;
  logic signed [RateW-1:0] ramp_q, ramp_d;

  logic signed [15:0] err_raw, err;
  logic        [15:0] abs_err;
  logic        [RateW-1:0] abs_rate;
  logic signed [RateW:0]   neg_rate;
  logic signed [31:0] prod_a;
  logic signed [40:0] prod_r;
  logic signed [33:0] cmd_sum, cmd_hi, cmd_lo;
  logic signed [RateW:0] delta_raw, delta, slew_pos, slew_neg, ramp_sum;
  logic near;

  // angle error, wrapped into [-pi, pi) by one add or subtract of 2*pi
  assign err_raw = $signed({item_i.target_angle[AngleW-1], item_i.target_angle})
                 - $signed({item_i.measured_angle[AngleW-1], item_i.measured_angle});

  always_comb begin
    if (err_raw >= PI_Q12) begin
      err = err_raw - TWO_PI_Q12;
    end else if (err_raw < -PI_Q12) begin
      err = err_raw + TWO_PI_Q12;
    end else begin
      err = err_raw;
    end
  end

  assign abs_err  = err[15] ? 16'(-err) : 16'(err);
  // -(-2^23) is 2^23, still exact as an unsigned 24-bit value
  assign abs_rate = item_i.measured_rate[RateW-1] ? RateW'(-$signed(item_i.measured_rate))
                                                  : item_i.measured_rate;
  assign neg_rate = -$signed({item_i.measured_rate[RateW-1], item_i.measured_rate});

  assign near = (abs_err < {2'b00, cfg_i.enter_angle_limit})
             && ({1'b0, abs_rate} < {2'b00, cfg_i.enter_rate_limit});

  assign run_inc = (run_q == RUN_MAX) ? run_q : run_q + 4'd1;

  // settle hysteresis; the run counter is left alone while settled
  always_comb begin
    run_d     = run_q;
    settled_d = settled_q;
    if (settled_q) begin
      if (abs_err > {2'b00, cfg_i.exit_angle_limit}) begin
        settled_d = 1'b0;
      end
    end else if (near) begin
      run_d     = run_inc;
      settled_d = (run_inc >= SETTLE_COUNT);
    end else begin
      run_d = '0;
    end
  end

  // state feedback; arithmetic shift gives the floor rounding
  assign prod_a  = $signed(cfg_i.gain_angle) * err;
  assign prod_r  = $signed(cfg_i.gain_rate) * neg_rate;
  assign cmd_sum = 34'(prod_a >>> 8) + 34'(prod_r >>> 8);

  // ceiling first, floor second: an inverted window ends on the floor
  assign cmd_hi = (cmd_sum > 34'($signed(cfg_i.speed_ceiling)))
                ? 34'($signed(cfg_i.speed_ceiling)) : cmd_sum;
  assign cmd_lo = (cmd_hi < 34'($signed(cfg_i.speed_floor)))
                ? 34'($signed(cfg_i.speed_floor)) : cmd_hi;

  assign slew_pos  = $signed({9'd0, cfg_i.slew_step});
  assign slew_neg  = -slew_pos;
  assign delta_raw = $signed(cmd_lo[RateW:0]) - $signed({ramp_q[RateW-1], ramp_q});

  always_comb begin
    if (delta_raw > slew_pos) begin
      delta = slew_pos;
    end else if (delta_raw < slew_neg) begin
      delta = slew_neg;
    end else begin
      delta = delta_raw;
    end
  end

  assign ramp_sum = $signed({ramp_q[RateW-1], ramp_q}) + delta;
  assign ramp_d   = settled_d ? '0 : $signed(ramp_sum[RateW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settled_q <= 1'b0;
      run_q     <= '0;
      ramp_q    <= '0;
    end else if (step_i) begin
      settled_q <= settled_d;
      run_q     <= run_d;
      ramp_q    <= ramp_d;
    end
  end

  assign result_o.speed_command = ramp_d;
  assign result_o.in_position   = settled_d;

`ifndef ASSERT_OFF
  a_settled_ramp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settled_q |-> (ramp_q == '0))
    else $error("ramp not zero while settled");

  a_settle_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(settled_q) |-> (run_q >= SETTLE_COUNT))
    else $error("settled without enough quiet ticks");
`endif

endmodule

`default_nettype wire

// ===== sim/plsr_speed_check.sv =====
`timescale 1ns / 1ps
// Transfer monitor for position_loop_settle_and_slew: tracks settings, predicts each
// speed result and compares it with what leaves the block. Depends on plsr_pkg.
module plsr_speed_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [55:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output int          mismatch_count_o,
  output int          outstanding_o
);
  import plsr_pkg::*;

  longint gain_angle_q, gain_rate_q, ceiling_q, floor_q, slew_q;
  longint enter_angle_q, exit_angle_q, enter_rate_q;
  logic            settled_q;
  logic [RunW-1:0] run_q;
  longint          ramp_q;

  result_t speed_expect_q[$];
  int      mismatches;

  initial begin
    mismatch_count_o = 0;
    outstanding_o    = 0;
  end

  // one control tick of the loop; updates the predicted loop state
  function automatic result_t tick_response(logic [AngleW-1:0] tgt, logic [AngleW-1:0] meas,
                                            logic [RateW-1:0] rate_f);
    longint  err, aerr, rate, arate, cmd, delta;
    result_t res;
    err = longint'($signed(tgt)) - longint'($signed(meas));
    if (err >= longint'(PI_Q12)) err -= longint'(TWO_PI_Q12);
    else if (err < -longint'(PI_Q12)) err += longint'(TWO_PI_Q12);
    rate  = longint'($signed(rate_f));
    aerr  = (err < 0) ? -err : err;
    arate = (rate < 0) ? -rate : rate;

    if (settled_q) begin
      if (aerr > exit_angle_q) settled_q = 1'b0;
    end else if (aerr < enter_angle_q && arate < enter_rate_q) begin
      // run counter saturates and survives leaving the settled state
      if (run_q < RUN_MAX) run_q = run_q + 1'b1;
      if (run_q >= SETTLE_COUNT) settled_q = 1'b1;
    end else begin
      run_q = '0;
    end

    if (settled_q) begin
      ramp_q = 0;
    end else begin
      cmd = ((gain_angle_q * err) >>> 8) + ((gain_rate_q * -rate) >>> 8);
      if (cmd > ceiling_q) cmd = ceiling_q;
      if (cmd < floor_q) cmd = floor_q;
      delta = cmd - ramp_q;
      if (delta > slew_q) delta = slew_q;
      else if (delta < -slew_q) delta = -slew_q;
      ramp_q += delta;
    end

    res.speed_command = ramp_q[RateW-1:0];
    res.in_position   = settled_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      gain_angle_q  = 0;
      gain_rate_q   = 0;
      ceiling_q     = 8388607;
      floor_q       = -8388608;
      slew_q        = 8;
      enter_angle_q = 21;
      exit_angle_q  = 43;
      enter_rate_q  = 286;
      settled_q     = 1'b0;
      run_q         = '0;
      ramp_q        = 0;
      speed_expect_q.delete();
      mismatches    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_GAIN_ANGLE:  gain_angle_q  = longint'($signed(cfg_data_i[GainW-1:0]));
          REG_GAIN_RATE:   gain_rate_q   = longint'($signed(cfg_data_i[GainW-1:0]));
          REG_SPEED_CEIL:  ceiling_q     = longint'($signed(cfg_data_i[RateW-1:0]));
          REG_SPEED_FLOOR: floor_q       = longint'($signed(cfg_data_i[RateW-1:0]));
          REG_SLEW_STEP:   slew_q        = longint'(cfg_data_i[SlewW-1:0]);
          REG_ENTER_ANGLE: enter_angle_q = longint'(cfg_data_i[ALimW-1:0]);
          REG_EXIT_ANGLE:  exit_angle_q  = longint'(cfg_data_i[ALimW-1:0]);
          REG_ENTER_RATE:  enter_rate_q  = longint'(cfg_data_i[RLimW-1:0]);
          default: ;
        endcase
      end

      if (m_tvalid_i && m_tready_i) begin
        if (speed_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing expected: tdata %h", $realtime, m_tdata_i);
        end else begin
          want = speed_expect_q.pop_front();
          if (m_tdata_i[RateW-1:0] !== want.speed_command ||
              m_tdata_i[RateW] !== want.in_position) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: speed_command exp %0d got %0d, in_position exp %0b got %0b",
                       $realtime, $signed(want.speed_command),
                       $signed(m_tdata_i[RateW-1:0]), want.in_position, m_tdata_i[RateW]);
          end
        end
      end

      if (s_tvalid_i && s_tready_i)
        speed_expect_q.push_back(tick_response(s_tdata_i[14:0], s_tdata_i[29:15],
                                               s_tdata_i[53:30]));
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= speed_expect_q.size();
  end

endmodule

// ===== sim/position_loop_settle_and_slew_test.sv =====
`timescale 1ns / 1ps
// Top of the position loop testbench: clock, reset, tick and settings stimulus, verdict.
// Depends on plsr_pkg, position_loop_settle_and_slew and plsr_speed_check.
module position_loop_settle_and_slew_test;
  import plsr_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [23:0] cfg_data_i;

  int mismatch_count;
  int outstanding;
  bit quiet = 1'b0;  // no idling on either side while set

  always #10 clk_i = ~clk_i;

  position_loop_settle_and_slew dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  plsr_speed_check speed_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  initial begin
    #10_000_000;
    $display("position_loop_settle_and_slew_test failed");
    $finish;
  end

  // result side backpressure
  initial begin : result_stall
    int hold;
    m_axis_tready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold == 0 && !quiet && $urandom_range(0, 11) == 0) hold = $urandom_range(1, 17);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_tick(int tgt, int meas, int rate);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, 24'(rate), 15'(meas), 15'(tgt)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop sending and wait until every result has come back
  task automatic drain_loop();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic set_reg(reg_idx_e idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_settings(logic [23:0] ga, logic [23:0] gr, logic [23:0] ceil_v,
                               logic [23:0] floor_v, logic [23:0] slew,
                               logic [23:0] enter_a, logic [23:0] exit_a,
                               logic [23:0] enter_r);
    drain_loop();
    repeat (4) @(negedge clk_i);
    set_reg(REG_GAIN_ANGLE, ga);
    set_reg(REG_GAIN_RATE, gr);
    set_reg(REG_SPEED_CEIL, ceil_v);
    set_reg(REG_SPEED_FLOOR, floor_v);
    set_reg(REG_SLEW_STEP, slew);
    set_reg(REG_ENTER_ANGLE, enter_a);
    set_reg(REG_EXIT_ANGLE, exit_a);
    set_reg(REG_ENTER_RATE, enter_r);
  endtask

  // segments of near-target ticks (to reach settling), raw noise, and wrap-around errors
  task automatic random_ticks(int count, int angle_span, int rate_span);
    int left, seg, mode, tgt, meas, rate;
    left = count;
    while (left > 0) begin
      seg = $urandom_range(4, 30);
      if (seg > left) seg = left;
      mode = $urandom_range(0, 9);
      repeat (seg) begin
        meas = int'($urandom_range(0, 32767)) - 16384;
        rate = int'($urandom_range(0, 2 * rate_span)) - rate_span;
        if (mode < 6) begin
          tgt = meas + int'($urandom_range(0, 2 * angle_span)) - angle_span;
          if ($urandom_range(0, 15) == 0) tgt = tgt + 4 * angle_span + 1;
        end else if (mode < 8) begin
          tgt  = int'($urandom_range(0, 32767));
          rate = int'($urandom_range(0, 24'hFFFFFF));
        end else begin
          meas = 12868 - int'($urandom_range(1, 300));
          if ($urandom_range(0, 1) == 1) meas = -meas;
          tgt = -meas + int'($urandom_range(0, 2 * angle_span)) - angle_span;
        end
        send_tick(tgt, meas, rate);
      end
      left -= seg;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_GAIN_ANGLE;
    cfg_data_i    = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed ticks
    load_settings(24'd256, 24'd128, 24'd4000, 24'(-4000), 24'd500, 24'd21, 24'd43, 24'd286);
    send_tick(12867, -12868, 0);
    send_tick(-12868, 12867, 0);
    send_tick(16383, -16384, 8388607);
    send_tick(-16384, 16383, -8388608);
    send_tick(0, 0, -8388608);
    send_tick(0, 0, 8388607);
    send_tick(12867, 0, 0);
    send_tick(-12868, 0, 0);
    send_tick(0, -12868, 0);
    repeat (11) send_tick(100, 100, 5);  // settles on the tenth
    send_tick(144, 100, 0);              // just over exit limit
    send_tick(100, 100, 0);              // run counter kept from before settles again at once
    send_tick(143, 100, 0);              // at exit limit: stays settled
    send_tick(0, 100, 0);
    send_tick(100, 100, 286);            // rate at limit clears the run

    load_settings(24'($urandom_range(0, 1024)), 24'($urandom_range(0, 512)), 24'd200000,
                  24'(-200000), 24'd3000, 24'd21, 24'd43, 24'd286);
    random_ticks(240, 90, 600);

    load_settings(24'h008000, 24'h007FFF, 24'h7FFFFF, 24'h800000, 24'h00FFFF,
                  24'd12868, 24'd12868, 24'h7FFFFF);
    random_ticks(240, 12868, 8388607);

    // inverted clamp window, frozen ramp, zero limits
    load_settings(24'h007FFF, 24'h008000, 24'(-1000), 24'd1000, 24'd0, 24'd0, 24'd0, 24'd0);
    random_ticks(240, 50, 500);

    load_settings(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                  24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                  24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                  24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)));
    random_ticks(240, 200, 5000);

    quiet = 1'b1;
    load_settings(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                  24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'hFFFFFF, 24'h003FFF, 24'hFFFFFF);
    random_ticks(240, 16383, 8388607);
    quiet = 1'b0;

    load_settings(24'($urandom_range(0, 2048)), 24'($urandom_range(0, 65535)), 24'd500000,
                  24'(-500000), 24'($urandom_range(1, 20000)), 24'd100, 24'd100, 24'd5000);
    random_ticks(240, 150, 8000);

    // enter limit above exit limit
    load_settings(24'($urandom_range(0, 65535)), 24'($urandom_range(0, 4096)), 24'd30000,
                  24'(-20000), 24'($urandom_range(1, 4000)), 24'd500, 24'd50, 24'd3000);
    random_ticks(240, 600, 3000);

    load_settings(24'($urandom_range(0, 65535)), 24'($urandom_range(0, 65535)),
                  24'd1000000, 24'(-1000000), 24'($urandom_range(1, 65535)), 24'd40, 24'd80,
                  24'd2000);
    quiet = 1'b1;
    random_ticks(240, 120, 3000);

    drain_loop();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0)
      $display("position_loop_settle_and_slew_test passed");
    else
      $display("position_loop_settle_and_slew_test failed");
    $finish;
  end

endmodule
